[hdl/aipg_pkg.sv]
// Package for the arpeggio / impulse pattern generator.
// Holds the register map, field widths and the chord note table.
// No dependencies.
`timescale 1ns / 1ps

package aipg_pkg;

	localparam int TABLE_NOTES = 16;
	localparam int CHORD_COUNT = 4;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_MODE          = 3'd0;
	localparam logic [2:0] REG_HIT_COUNT     = 3'd1;
	localparam logic [2:0] REG_BAR_COUNT     = 3'd2;
	localparam logic [2:0] REG_BUFFER_LENGTH = 3'd3;
	localparam logic [2:0] REG_NOTE_LENGTH   = 3'd4;
	localparam logic [2:0] REG_GATE_LENGTH   = 3'd5;

	localparam logic [6:0]  BAR_COUNT_RESET   = 7'd8;
	localparam logic [23:0] NOTE_LENGTH_RESET = 24'd11250;
	localparam logic [23:0] GATE_LENGTH_RESET = 24'd7875;

	localparam logic [1:0] LAST_CHORD = 2'(CHORD_COUNT - 1);

	typedef logic [17:0] freq_t;

	// Chord table: A minor, G, F and E major, sixteen notes each, in 0.01 Hz.
	function automatic freq_t note_freq(input logic [5:0] idx);
		freq_t f;
		case (idx)
			6'd0:  f = 18'd5500;   6'd1:  f = 18'd6541;   6'd2:  f = 18'd8241;
			6'd3:  f = 18'd11000;  6'd4:  f = 18'd13081;  6'd5:  f = 18'd16481;
			6'd6:  f = 18'd22000;  6'd7:  f = 18'd26163;  6'd8:  f = 18'd32963;
			6'd9:  f = 18'd44000;  6'd10: f = 18'd52325;  6'd11: f = 18'd65925;
			6'd12: f = 18'd88000;  6'd13: f = 18'd104650; 6'd14: f = 18'd131851;
			6'd15: f = 18'd176000;
			6'd16: f = 18'd4900;   6'd17: f = 18'd6174;   6'd18: f = 18'd7342;
			6'd19: f = 18'd9800;   6'd20: f = 18'd12347;  6'd21: f = 18'd14683;
			6'd22: f = 18'd19600;  6'd23: f = 18'd24694;  6'd24: f = 18'd29366;
			6'd25: f = 18'd39200;  6'd26: f = 18'd49388;  6'd27: f = 18'd58733;
			6'd28: f = 18'd78399;  6'd29: f = 18'd98777;  6'd30: f = 18'd117466;
			6'd31: f = 18'd156798;
			6'd32: f = 18'd4365;   6'd33: f = 18'd5500;   6'd34: f = 18'd6541;
			6'd35: f = 18'd8731;   6'd36: f = 18'd11000;  6'd37: f = 18'd13081;
			6'd38: f = 18'd17461;  6'd39: f = 18'd22000;  6'd40: f = 18'd26163;
			6'd41: f = 18'd34923;  6'd42: f = 18'd44000;  6'd43: f = 18'd52325;
			6'd44: f = 18'd69846;  6'd45: f = 18'd88000;  6'd46: f = 18'd104650;
			6'd47: f = 18'd139691;
			6'd48: f = 18'd4120;   6'd49: f = 18'd5191;   6'd50: f = 18'd6174;
			6'd51: f = 18'd8241;   6'd52: f = 18'd10383;  6'd53: f = 18'd12347;
			6'd54: f = 18'd16481;  6'd55: f = 18'd20765;  6'd56: f = 18'd24694;
			6'd57: f = 18'd32963;  6'd58: f = 18'd41530;  6'd59: f = 18'd49388;
			6'd60: f = 18'd65925;  6'd61: f = 18'd83061;  6'd62: f = 18'd98777;
			6'd63: f = 18'd131851;
			default: f = '0;
		endcase
		return f;
	endfunction

endpackage

[hdl/arpeggio_impulse_pattern_generator_top.sv]
// Arpeggio / impulse pattern generator, one audio sample per beat.
// A result beat appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle unless m_tready stalls the result. A write to
// hit_count or buffer_length starts a remainder sweep (one bit per cycle) that
// holds s_tready low. Reset (arst_n low, asynchronous) clears all counters and
// loads register defaults. Depends on aipg_pkg.
`timescale 1ns / 1ps

module arpeggio_impulse_pattern_generator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] start_req
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [0] gate, [18:1] freq_centihz
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import aipg_pkg::*;

	// Configuration registers.
	logic        mode_q;
	logic [15:0] hit_count_q;
	logic [6:0]  bar_count_q;
	logic [23:0] buffer_length_q;
	logic [23:0] note_length_q;
	logic [23:0] gate_length_q;

	// Sample counters.
	logic [23:0] sample_index_q;
	logic [23:0] note_position_q;
	logic [9:0]  note_number_q;
	logic [1:0]  chord_index_q;
	logic [8:0]  note_in_chord_q;
	logic [39:0] hit_acc_q;

	// hit_rem_q is hit_acc mod buffer_length; hit_step_q is hit_count mod buffer_length.
	logic [23:0] hit_rem_q;
	logic [23:0] hit_step_q;

	// Remainder sweep.
	logic        div_busy_q;
	logic [5:0]  div_cnt_q;
	logic [39:0] div_a_q;
	logic [15:0] div_h_q;

	logic        m_tvalid_q;
	logic        gate_q;
	freq_t       freq_q;

	logic        cfg_wr;
	logic [2:0]  cfg_idx;
	logic        in_acc;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[4:2];

	always_comb begin
		case (cfg_idx)
			REG_MODE:          prdata = {31'd0, mode_q};
			REG_HIT_COUNT:     prdata = {16'd0, hit_count_q};
			REG_BAR_COUNT:     prdata = {25'd0, bar_count_q};
			REG_BUFFER_LENGTH: prdata = {8'd0, buffer_length_q};
			REG_NOTE_LENGTH:   prdata = {8'd0, note_length_q};
			REG_GATE_LENGTH:   prdata = {8'd0, gate_length_q};
			default:           prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= 1'b0;
			hit_count_q     <= '0;
			bar_count_q     <= BAR_COUNT_RESET;
			buffer_length_q <= '0;
			note_length_q   <= NOTE_LENGTH_RESET;
			gate_length_q   <= GATE_LENGTH_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_MODE:          mode_q          <= pwdata[0];
				REG_HIT_COUNT:     hit_count_q     <= pwdata[15:0];
				REG_BAR_COUNT:     bar_count_q     <= pwdata[6:0];
				REG_BUFFER_LENGTH: buffer_length_q <= pwdata[23:0];
				REG_NOTE_LENGTH:   note_length_q   <= pwdata[23:0];
				REG_GATE_LENGTH:   gate_length_q   <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	// One restoring step of a remainder: shift in a dividend bit, subtract once.
	function automatic logic [23:0] rem_step(input logic [23:0] rem, input logic b,
			input logic [23:0] len);
		logic [24:0] t;
		t = {rem, b};
		if (t >= {1'b0, len})
			t = t - {1'b0, len};
		return t[23:0];
	endfunction

	// Per-sample datapath, from the current state and the incoming beat.
	logic        start;
	logic [23:0] cur_si, cur_np;
	logic [9:0]  cur_nn;
	logic [1:0]  cur_ci;
	logic [8:0]  cur_nic;
	logic [39:0] cur_acc;
	logic [23:0] cur_rem;
	logic [6:0]  bars;
	logic [9:0]  note_total;
	logic [7:0]  per_chord;
	logic        in_buf;
	logic        gate_d;
	freq_t       freq_d;
	logic [24:0] np_inc;
	logic [9:0]  nic_inc;
	logic [24:0] rem_sum;
	logic [24:0] hit_end;

	assign start   = s_tdata[0];
	assign cur_si  = start ? '0 : sample_index_q;
	assign cur_np  = start ? '0 : note_position_q;
	assign cur_nn  = start ? '0 : note_number_q;
	assign cur_ci  = start ? '0 : chord_index_q;
	assign cur_nic = start ? '0 : note_in_chord_q;
	assign cur_acc = start ? '0 : hit_acc_q;
	assign cur_rem = start ? '0 : hit_rem_q;

	assign bars        = (bar_count_q != '0) ? bar_count_q : BAR_COUNT_RESET;
	assign note_total  = {bars, 3'b000};
	assign per_chord   = {bars, 1'b0};
	assign in_buf      = cur_si < buffer_length_q;
	assign np_inc      = {1'b0, cur_np} + 25'd1;
	assign nic_inc     = {1'b0, cur_nic} + 10'd1;
	assign rem_sum     = {1'b0, cur_rem} + {1'b0, hit_step_q};
	assign hit_end     = {1'b0, cur_rem} + {9'd0, hit_count_q};

	always_comb begin
		gate_d = 1'b0;
		freq_d = '0;
		if (in_buf) begin
			if (mode_q) begin
				// A multiple of the buffer length falls in [acc, acc + hits - 1].
				if (hit_count_q != '0 &&
						(cur_rem == '0 || {8'd0, hit_count_q} >= buffer_length_q ||
						hit_end > {1'b0, buffer_length_q}))
					gate_d = 1'b1;
			end else if (note_length_q != '0 && cur_nn < note_total) begin
				freq_d = note_freq({cur_ci, cur_nic[3:0]});
				gate_d = cur_np < gate_length_q;
			end
		end
	end

	assign s_tready = !div_busy_q && (!m_tvalid_q || m_tready);
	assign in_acc   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_index_q  <= '0;
			note_position_q <= '0;
			note_number_q   <= '0;
			chord_index_q   <= '0;
			note_in_chord_q <= '0;
			hit_acc_q       <= '0;
			hit_rem_q       <= '0;
			hit_step_q      <= '0;
			div_busy_q      <= 1'b0;
			div_cnt_q       <= '0;
		end else if (cfg_wr && (cfg_idx inside {REG_HIT_COUNT, REG_BUFFER_LENGTH})) begin
			// Both remainders go stale; rebuild them from the accumulator and hit_count.
			div_busy_q <= 1'b1;
			div_cnt_q  <= 6'd39;
			hit_rem_q  <= '0;
			hit_step_q <= '0;
		end else if (div_busy_q) begin
			hit_rem_q <= rem_step(hit_rem_q, div_a_q[39], buffer_length_q);
			if (div_cnt_q < 6'd16)
				hit_step_q <= rem_step(hit_step_q, div_h_q[15], buffer_length_q);
			if (div_cnt_q == '0)
				div_busy_q <= 1'b0;
			else
				div_cnt_q <= div_cnt_q - 6'd1;
		end else if (in_acc) begin
			sample_index_q  <= cur_si;
			note_position_q <= cur_np;
			note_number_q   <= cur_nn;
			chord_index_q   <= cur_ci;
			note_in_chord_q <= cur_nic;
			hit_acc_q       <= cur_acc;
			hit_rem_q       <= cur_rem;
			if (in_buf) begin
				sample_index_q <= cur_si + 24'd1;
				hit_acc_q      <= cur_acc + {24'd0, hit_count_q};
				hit_rem_q      <= (rem_sum >= {1'b0, buffer_length_q}) ?
					24'(rem_sum - {1'b0, buffer_length_q}) : rem_sum[23:0];
				if (np_inc >= {1'b0, note_length_q}) begin
					note_position_q <= '0;
					if (cur_nn < note_total) begin
						note_number_q <= cur_nn + 10'd1;
						if (nic_inc >= {2'd0, per_chord} && cur_ci < LAST_CHORD) begin
							chord_index_q   <= cur_ci + 2'd1;
							note_in_chord_q <= '0;
						end else begin
							note_in_chord_q <= nic_inc[8:0];
						end
					end
				end else begin
					note_position_q <= np_inc[23:0];
				end
			end
		end
	end

	// Dividend shifters for the sweep; no reset needed.
	always_ff @(posedge clk) begin
		if (cfg_wr && (cfg_idx inside {REG_HIT_COUNT, REG_BUFFER_LENGTH})) begin
			div_a_q <= hit_acc_q;
			div_h_q <= (cfg_idx == REG_HIT_COUNT) ? pwdata[15:0] : hit_count_q;
		end else if (div_busy_q) begin
			div_a_q <= {div_a_q[38:0], 1'b0};
			if (div_cnt_q < 6'd16)
				div_h_q <= {div_h_q[14:0], 1'b0};
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (in_acc)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			gate_q <= gate_d;
			freq_q <= freq_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'd0, freq_q, gate_q};

endmodule

[tb/arpeggio_impulse_pattern_generator_top_tb.sv]
// Self-checking testbench for arpeggio_impulse_pattern_generator_top.
// Drives sample beats and register writes, predicts each result beat in place.
// Depends on aipg_pkg and the top level RTL.
`timescale 1ns / 1ps

module arpeggio_impulse_pattern_generator_top_tb;
	import aipg_pkg::*;

	localparam int ITEM_GOAL   = 1050;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 80;

	typedef struct packed {
		logic        mode;
		logic [15:0] hits;
		logic [6:0]  bars;
		logic [23:0] buf_len;
		logic [23:0] note_len;
		logic [23:0] gate_len;
	} pattern_cfg_t;

	typedef struct packed {
		logic        gate;
		logic [17:0] freq;
	} sample_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;   // [0] start_req
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;          // [0] gate, [18:1] freq_centihz
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = 5'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	arpeggio_impulse_pattern_generator_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Chord tones in 0.01 Hz: A minor, G, F, E major, sixteen each.
	bit [17:0] chord_freq [0:63] = '{
		18'd5500, 18'd6541, 18'd8241, 18'd11000, 18'd13081, 18'd16481, 18'd22000, 18'd26163,
		18'd32963, 18'd44000, 18'd52325, 18'd65925, 18'd88000, 18'd104650, 18'd131851,
		18'd176000,
		18'd4900, 18'd6174, 18'd7342, 18'd9800, 18'd12347, 18'd14683, 18'd19600, 18'd24694,
		18'd29366, 18'd39200, 18'd49388, 18'd58733, 18'd78399, 18'd98777, 18'd117466,
		18'd156798,
		18'd4365, 18'd5500, 18'd6541, 18'd8731, 18'd11000, 18'd13081, 18'd17461, 18'd22000,
		18'd26163, 18'd34923, 18'd44000, 18'd52325, 18'd69846, 18'd88000, 18'd104650,
		18'd139691,
		18'd4120, 18'd5191, 18'd6174, 18'd8241, 18'd10383, 18'd12347, 18'd16481, 18'd20765,
		18'd24694, 18'd32963, 18'd41530, 18'd49388, 18'd65925, 18'd83061, 18'd98777,
		18'd131851
	};

	// Predictor state, mirrors the block's counters and registers.
	pattern_cfg_t model_cfg;
	bit [23:0]    smp_idx;
	bit [23:0]    note_pos;
	bit [9:0]     note_num;
	bit [1:0]     chord;
	bit [8:0]     chord_step;
	bit [39:0]    hit_acc;

	bit           start_pending [$];
	sample_out_t  sample_due [$];
	sample_out_t  want_now;
	int           owed = 0;
	int           errors = 0;
	int           items_sent = 0;
	int           results_seen = 0;
	int           gates_seen = 0;
	int           tones_seen = 0;
	int           phases = 0;
	int           impulse_phases = 0;
	int           stall_cycles = 0;
	int           hold_left = 0;
	bit           hold_req = 1'b0;
	bit           steady = 1'b0;
	bit           s_taken = 1'b0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic sample_out_t next_sample(input bit start);
		int unsigned bars, notes, per_chord;
		bit [63:0]   a, b, len;
		sample_out_t r;
		r = '0;
		bars = (model_cfg.bars != 0) ? model_cfg.bars : 8;
		notes = bars * 8;
		per_chord = notes / CHORD_COUNT;
		if (start) begin
			smp_idx = '0;
			note_pos = '0;
			note_num = '0;
			chord = '0;
			chord_step = '0;
			hit_acc = '0;
		end
		if (smp_idx < model_cfg.buf_len) begin
			if (model_cfg.mode) begin
				// An impulse lands where the running hit total crosses a buffer multiple.
				a = hit_acc;
				b = a + model_cfg.hits;
				len = model_cfg.buf_len;
				if (model_cfg.hits != 0 && (a == 0 || (b - 1) / len != (a - 1) / len))
					r.gate = 1'b1;
			end else if (model_cfg.note_len != 0 && note_num < notes) begin
				r.freq = chord_freq[{chord, chord_step[3:0]}];
				r.gate = note_pos < model_cfg.gate_len;
			end
			smp_idx = smp_idx + 1'b1;
			hit_acc = hit_acc + model_cfg.hits;
			if (note_pos + 32'd1 >= model_cfg.note_len) begin
				note_pos = '0;
				if (note_num < notes) begin
					note_num = note_num + 1'b1;
					if (chord_step + 32'd1 >= per_chord && chord < LAST_CHORD) begin
						chord = chord + 1'b1;
						chord_step = '0;
					end else begin
						chord_step = chord_step + 1'b1;
					end
				end
			end else begin
				note_pos = note_pos + 1'b1;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		errors++;
		// Keep the log readable if the block goes badly wrong.
		if (errors <= 40)
			$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// Sender: holds a beat until it is taken, then offers the next one or idles.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || s_taken) begin
				if (start_pending.size() != 0 && (steady || $urandom_range(0, 99) >= 33)) begin
					s_tdata <= {7'd0, start_pending.pop_front()};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random back-pressure, plus a long hold-off on request.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= steady || ($urandom_range(0, 99) >= 33);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			s_taken <= s_tvalid && s_tready;
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_MODE:          model_cfg.mode = pwdata[0];
					REG_HIT_COUNT:     model_cfg.hits = pwdata[15:0];
					REG_BAR_COUNT:     model_cfg.bars = pwdata[6:0];
					REG_BUFFER_LENGTH: model_cfg.buf_len = pwdata[23:0];
					REG_NOTE_LENGTH:   model_cfg.note_len = pwdata[23:0];
					REG_GATE_LENGTH:   model_cfg.gate_len = pwdata[23:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				want_now = next_sample(s_tdata[0]);
				sample_due.push_back(want_now);
				gates_seen += want_now.gate;
				tones_seen += (want_now.freq != 0);
			end
			if (m_tvalid && m_tready) begin
				if (sample_due.size() == 0) begin
					report_mismatch("unexpected result beat", m_tdata, 0);
				end else begin
					want_now = sample_due.pop_front();
					owed--;
					results_seen++;
					if (m_tdata[0] !== want_now.gate)
						report_mismatch("gate", m_tdata[0], want_now.gate);
					if (m_tdata[18:1] !== want_now.freq)
						report_mismatch("freq_centihz", m_tdata[18:1], want_now.freq);
				end
			end
		end
	end

	// Watchdog on cycles with no beat and no register write.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("[%0t] no progress for %0d cycles", $time, STALL_LIMIT);
			$display("simulation failed");
			$finish;
		end
	end

	task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic queue_item(input bit start);
		start_pending.push_back(start);
		owed++;
		items_sent++;
	endtask

	// Waits for the block to drain, programs all registers, then queues n samples.
	// A nonzero period raises start_req every period samples from the first one.
	task automatic run_buffer(input pattern_cfg_t c, input int n, input int period,
			input int noise_pct);
		int pos;
		bit st;
		pos = 0;
		while (owed != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		apb_write(REG_MODE, {31'd0, c.mode});
		apb_write(REG_HIT_COUNT, {16'd0, c.hits});
		apb_write(REG_BAR_COUNT, {25'd0, c.bars});
		apb_write(REG_BUFFER_LENGTH, {8'd0, c.buf_len});
		apb_write(REG_NOTE_LENGTH, {8'd0, c.note_len});
		apb_write(REG_GATE_LENGTH, {8'd0, c.gate_len});
		phases++;
		impulse_phases += c.mode;
		for (int k = 0; k < n; k++) begin
			st = (period != 0 && pos == 0) || ($urandom_range(0, 99) < noise_pct);
			if (period != 0)
				pos = (pos + 1) % period;
			queue_item(st);
		end
	endtask

	function automatic pattern_cfg_t pick_cfg();
		pattern_cfg_t c;
		c.mode = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 4))
			0: c.hits = 16'd0;
			1: c.hits = 16'hFFFF;
			2: c.hits = 16'($urandom_range(1, 8));
			default: c.hits = 16'($urandom);
		endcase
		case ($urandom_range(0, 9))
			0: c.buf_len = 24'd0;
			1: c.buf_len = 24'hFFFFFF;
			default: c.buf_len = 24'($urandom_range(1, 90));
		endcase
		case ($urandom_range(0, 7))
			0: c.bars = 7'd0;
			1: c.bars = 7'd127;
			2: c.bars = 7'($urandom);
			default: c.bars = 7'($urandom_range(1, 3));
		endcase
		case ($urandom_range(0, 7))
			0: c.note_len = 24'd0;
			1: c.note_len = 24'hFFFFFF;
			2: c.note_len = 24'($urandom);
			default: c.note_len = 24'($urandom_range(1, 6));
		endcase
		case ($urandom_range(0, 5))
			0: c.gate_len = 24'd0;
			1: c.gate_len = 24'hFFFFFF;
			default: c.gate_len =
				24'($urandom_range(0, (c.note_len < 8) ? c.note_len + 2 : 8));
		endcase
		return c;
	endfunction

	initial begin
		pattern_cfg_t c;
		int n, period;
		model_cfg = '{1'b0, 16'd0, BAR_COUNT_RESET, 24'd0, NOTE_LENGTH_RESET, GATE_LENGTH_RESET};
		void'(next_sample(1'b1));
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset values leave a zero-length buffer, so every sample is past its end.
		queue_item(1'b0);
		queue_item(1'b1);
		// One bar with two-sample notes: all four chords, then silence after the last note.
		// No start_req here, so the zeroed counters begin the buffer on their own.
		run_buffer('{1'b0, 16'd0, 7'd1, 24'd17, 24'd2, 24'd1}, 17, 0, 0);
		// Impulse mode with no hits, then arpeggio mode with zero note length.
		run_buffer('{1'b1, 16'd0, 7'd1, 24'd3, 24'd2, 24'd1}, 3, 4, 0);
		run_buffer('{1'b0, 16'd5, 7'd1, 24'd3, 24'd0, 24'd1}, 3, 4, 0);

		while (items_sent < ITEM_GOAL) begin
			c = pick_cfg();
			n = $urandom_range(20, 70);
			if (phases == 8 || phases == 20)
				n = 70;
			steady = (phases >= 10 && phases < 14);
			// Some phases carry on without a start, so register changes land mid-buffer.
			if ($urandom_range(0, 4) == 0)
				period = 0;
			else if (c.buf_len <= 200)
				period = c.buf_len + $urandom_range(0, 4);
			else
				period = n + 1;
			run_buffer(c, n, period, ($urandom_range(0, 3) == 0) ? 5 : 0);
			// Stall the output long enough to back the block up into its input.
			if (phases == 9 || phases == 21)
				hold_req = 1'b1;
		end
		steady = 1'b0;

		while (owed != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		$display("Ran %0d register settings (%0d impulse), %0d samples, %0d results checked.",
			phases, impulse_phases, items_sent, results_seen);
		$display("Expected gate high on %0d samples, a tone on %0d; %0d mismatches.",
			gates_seen, tones_seen, errors);
		if (errors == 0 && sample_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[sim.f]
hdl/aipg_pkg.sv
hdl/arpeggio_impulse_pattern_generator_top.sv
tb/arpeggio_impulse_pattern_generator_top_tb.sv
